/* hw/rtl/jsqs_pkg.sv */
// Job slot quantum scheduler: shared widths, command codes, sequencer
// states and the operation/status types between controller and datapath.
// No dependencies.
package jsqs_pkg;

   localparam int SLOTS   = 4;
   localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int CMD_W   = 3;
   localparam int PID_W   = 8;
   localparam int MASK_W  = 4;
   localparam int JOBS_W  = 3;
   localparam int TICK_W  = 32;
   localparam int EXT_W   = (SLOTS > MASK_W) ? SLOTS : MASK_W;

   localparam logic [TICK_W-1:0] QUANTUM_RESET = 32'd25;

   localparam logic [CMD_W-1:0] CMD_LAUNCH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_KILL     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DETACH   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_KILL_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SERVICE  = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_EXEC,
      OP_STEP,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic out_free;
      logic step_push;
      logic step_run;
      logic last_idx;
      logic fin_push;
   } stat_type;

endpackage

/* hw/rtl/jsqs_ifs.sv */
// Handshake channels of the job slot quantum scheduler: command, result
// and quantum register write. Depends on jsqs_pkg.
interface jsqs_req_if;
   import jsqs_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [PID_W-1:0]  prog_id;
   logic [MASK_W-1:0] ended_mask;
   modport source (output valid, cmd, prog_id, ended_mask, input ready);
   modport sink   (input valid, cmd, prog_id, ended_mask, output ready);
endinterface

interface jsqs_rsp_if;
   import jsqs_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic              preempt;
   logic              run_valid;
   logic [PID_W-1:0]  run_id;
   logic              release_valid;
   logic [PID_W-1:0]  release_id;
   logic [JOBS_W-1:0] active_jobs;
   logic              last;
   modport source (output valid, status, preempt, run_valid, run_id, release_valid,
                   release_id, active_jobs, last, input ready);
   modport sink   (input valid, status, preempt, run_valid, run_id, release_valid,
                   release_id, active_jobs, last, output ready);
endinterface

interface jsqs_csr_if;
   import jsqs_pkg::*;
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] quantum;
   modport source (output valid, quantum, input ready);
   modport sink   (input valid, quantum, output ready);
endinterface

/* hw/rtl/jsqs_ctrl.sv */
// Sequencer of the job slot quantum scheduler: accepts a command, then
// issues execute, slot step and finish operations. Depends on jsqs_pkg.
module jsqs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [jsqs_pkg::CMD_W-1:0] req_cmd,
   output logic                       req_ready,
   input  jsqs_pkg::stat_type         stat,
   output jsqs_pkg::op_type           op
);
   import jsqs_pkg::*;

   state_type state_ff, state_in;
   logic      scan_cmd;

   assign scan_cmd = (req_cmd == CMD_TICK) || (req_cmd == CMD_KILL_ALL) ||
                     (req_cmd == CMD_SERVICE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = scan_cmd ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.out_free) begin
               op       = OP_EXEC;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!stat.step_push || stat.out_free) begin
               op = OP_STEP;
               if (stat.step_run) begin
                  state_in = ST_IDLE;
               end else if (stat.last_idx) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (!stat.fin_push || stat.out_free) begin
               op       = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/jsqs_datapath.sv */
// Datapath of the job slot quantum scheduler: slot table, job count, flags,
// tick counter, quantum register and result register. Depends on jsqs_pkg.
module jsqs_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [jsqs_pkg::CMD_W-1:0]  req_cmd,
   input  logic [jsqs_pkg::PID_W-1:0]  req_prog_id,
   input  logic [jsqs_pkg::MASK_W-1:0] req_ended_mask,
   input  logic                        csr_valid,
   input  logic [jsqs_pkg::TICK_W-1:0] csr_quantum,
   input  jsqs_pkg::op_type            op,
   output jsqs_pkg::stat_type          stat,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_status,
   output logic                        rsp_preempt,
   output logic                        rsp_run_valid,
   output logic [jsqs_pkg::PID_W-1:0]  rsp_run_id,
   output logic                        rsp_release_valid,
   output logic [jsqs_pkg::PID_W-1:0]  rsp_release_id,
   output logic [jsqs_pkg::JOBS_W-1:0] rsp_active_jobs,
   output logic                        rsp_last
);
   import jsqs_pkg::*;

   logic [PID_W-1:0]   slot_program_ff [SLOTS];
   logic [TICK_W-1:0]  slot_start_ff   [SLOTS];
   logic [SLOTS-1:0]   slot_active_ff, slot_active_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic               armed_ff, armed_in;
   logic               expired_ff, expired_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  quantum_ff;
   logic [CMD_W-1:0]   cmd_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [SLOT_IW-1:0] idx_ff, idx_in;
   logic               hit_ff, hit_in;
   logic               emitted_ff, emitted_in;

   logic               rsp_valid_ff;
   logic               rsp_status_ff, rsp_preempt_ff, rsp_run_valid_ff;
   logic               rsp_release_valid_ff, rsp_last_ff;
   logic [PID_W-1:0]   rsp_run_id_ff, rsp_release_id_ff;
   logic [JOBS_W-1:0]  rsp_jobs_ff;

   logic               push;
   logic               out_status, out_preempt, out_run_valid, out_release_valid;
   logic               out_last;
   logic [PID_W-1:0]   out_run_id, out_release_id;

   logic               prog_wr, start_wr;
   logic [SLOT_IW-1:0] prog_wr_idx, start_wr_idx;

   logic [SLOTS-1:0]   match_vec;
   logic [SLOTS-1:0]   gone_vec;
   logic [SLOTS-1:0]   after_vec;
   logic [EXT_W-1:0]   mask_ext;
   logic [SLOT_IW-1:0] free_idx;
   logic               free_any, match_any, pid_zero;
   logic [CNT_W-1:0]   total_dec;
   logic [TICK_W-1:0]  elapsed;
   logic               cur_active, cur_gone, out_free;

   assign mask_ext  = EXT_W'(mask_ff);
   assign gone_vec  = mask_ext[SLOTS-1:0];
   assign after_vec = (slot_active_ff >> idx_ff) >> 1;
   assign free_any  = ~&slot_active_ff;
   assign match_any = |match_vec;
   assign pid_zero  = (pid_ff == '0);
   assign total_dec = (total_ff != '0) ? total_ff - CNT_W'(1) : total_ff;
   assign elapsed   = tick_ff - slot_start_ff[idx_ff];
   assign cur_active = slot_active_ff[idx_ff];
   assign cur_gone   = gone_vec[idx_ff];
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = slot_active_ff[i] && (slot_program_ff[i] == pid_ff);
      end
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_active_ff[i]) begin
            free_idx = SLOT_IW'(i);
         end
      end
   end

   always_comb begin
      stat.out_free  = out_free;
      stat.step_push = cur_active &&
                       ((cmd_ff == CMD_KILL_ALL) || ((cmd_ff == CMD_SERVICE) && !cur_gone));
      stat.step_run  = (cmd_ff == CMD_SERVICE) && cur_active && !cur_gone;
      stat.last_idx  = (idx_ff == SLOT_IW'(SLOTS - 1));
      stat.fin_push  = !((cmd_ff == CMD_KILL_ALL) && emitted_ff);
   end

   always_comb begin
      slot_active_in    = slot_active_ff;
      total_in          = total_ff;
      armed_in          = armed_ff;
      expired_in        = expired_ff;
      tick_in           = tick_ff;
      idx_in            = idx_ff;
      hit_in            = hit_ff;
      emitted_in        = emitted_ff;
      prog_wr           = 1'b0;
      prog_wr_idx       = free_idx;
      start_wr          = 1'b0;
      start_wr_idx      = idx_ff;
      push              = 1'b0;
      out_status        = 1'b0;
      out_preempt       = 1'b0;
      out_run_valid     = 1'b0;
      out_run_id        = '0;
      out_release_valid = 1'b0;
      out_release_id    = '0;
      out_last          = 1'b1;
      unique case (op)
         OP_LOAD: begin
            idx_in     = '0;
            hit_in     = 1'b0;
            emitted_in = 1'b0;
            if (req_cmd == CMD_TICK) begin
               tick_in = tick_ff + TICK_W'(1);
            end
            if (req_cmd == CMD_KILL_ALL) begin
               total_in   = '0;
               armed_in   = 1'b0;
               expired_in = 1'b0;
            end
         end
         OP_EXEC: begin
            push = 1'b1;
            case (cmd_ff)
               CMD_LAUNCH: begin
                  if (pid_zero) begin
                     out_status = 1'b1;
                  end else if (!match_any) begin
                     if (free_any) begin
                        prog_wr                  = 1'b1;
                        start_wr                 = 1'b1;
                        start_wr_idx             = free_idx;
                        slot_active_in[free_idx] = 1'b1;
                        total_in                 = total_ff + CNT_W'(1);
                        armed_in                 = 1'b1;
                     end else begin
                        out_status = 1'b1;
                     end
                  end
               end
               CMD_KILL, CMD_DETACH: begin
                  if (pid_zero || !match_any) begin
                     out_status = 1'b1;
                  end else begin
                     slot_active_in = slot_active_ff & ~match_vec;
                     total_in       = total_dec;
                     if (total_dec == '0) begin
                        armed_in   = 1'b0;
                        expired_in = 1'b0;
                     end
                     if (cmd_ff == CMD_KILL) begin
                        out_release_valid = 1'b1;
                        out_release_id    = pid_ff;
                     end
                  end
               end
               CMD_QUERY: begin
                  if (armed_ff && (total_ff != '0) && expired_ff) begin
                     expired_in  = 1'b0;
                     out_preempt = 1'b1;
                  end
               end
               default: begin
                  out_status = 1'b1;
               end
            endcase
         end
         OP_STEP: begin
            idx_in = idx_ff + SLOT_IW'(1);
            case (cmd_ff)
               CMD_TICK: begin
                  if (cur_active && (elapsed >= quantum_ff)) begin
                     hit_in = 1'b1;
                  end
               end
               CMD_KILL_ALL: begin
                  if (cur_active) begin
                     push                   = 1'b1;
                     emitted_in             = 1'b1;
                     slot_active_in[idx_ff] = 1'b0;
                     out_release_valid      = 1'b1;
                     out_release_id         = slot_program_ff[idx_ff];
                     out_last               = ~|after_vec;
                  end
               end
               CMD_SERVICE: begin
                  if (cur_active) begin
                     if (cur_gone) begin
                        slot_active_in[idx_ff] = 1'b0;
                        total_in               = total_dec;
                     end else begin
                        push          = 1'b1;
                        start_wr      = 1'b1;
                        expired_in    = 1'b0;
                        out_run_valid = 1'b1;
                        out_run_id    = slot_program_ff[idx_ff];
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_FINISH: begin
            case (cmd_ff)
               CMD_TICK: begin
                  push = 1'b1;
                  if (armed_ff && (total_ff != '0) && hit_ff) begin
                     expired_in = 1'b1;
                  end
               end
               CMD_KILL_ALL: begin
                  push = !emitted_ff;
               end
               CMD_SERVICE: begin
                  push = 1'b1;
                  if (total_ff == '0) begin
                     armed_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_active_ff <= '0;
         total_ff       <= '0;
         armed_ff       <= 1'b0;
         expired_ff     <= 1'b0;
         tick_ff        <= '0;
         quantum_ff     <= QUANTUM_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         slot_active_ff <= slot_active_in;
         total_ff       <= total_in;
         armed_ff       <= armed_in;
         expired_ff     <= expired_in;
         tick_ff        <= tick_in;
         if (csr_valid) begin
            quantum_ff <= csr_quantum;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      emitted_ff <= emitted_in;
      if (op == OP_LOAD) begin
         cmd_ff  <= req_cmd;
         pid_ff  <= req_prog_id;
         mask_ff <= req_ended_mask;
      end
      if (prog_wr) begin
         slot_program_ff[prog_wr_idx] <= pid_ff;
      end
      if (start_wr) begin
         slot_start_ff[start_wr_idx] <= tick_ff;
      end
      if (push) begin
         rsp_status_ff        <= out_status;
         rsp_preempt_ff       <= out_preempt;
         rsp_run_valid_ff     <= out_run_valid;
         rsp_run_id_ff        <= out_run_id;
         rsp_release_valid_ff <= out_release_valid;
         rsp_release_id_ff    <= out_release_id;
         rsp_jobs_ff          <= JOBS_W'(total_in);
         rsp_last_ff          <= out_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_preempt       = rsp_preempt_ff;
   assign rsp_run_valid     = rsp_run_valid_ff;
   assign rsp_run_id        = rsp_run_id_ff;
   assign rsp_release_valid = rsp_release_valid_ff;
   assign rsp_release_id    = rsp_release_id_ff;
   assign rsp_active_jobs   = rsp_jobs_ff;
   assign rsp_last          = rsp_last_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result beat pushed into a full output register");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(SLOTS))
      else $error("job count above slot count");

   a_total_tracks: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD) |-> ($countones(slot_active_ff) == int'(total_ff)))
      else $error("job count differs from active slots at command start");

   a_kill_all_clears: assert property (@(posedge clock) disable iff (reset)
      ((op == OP_LOAD) && (req_cmd == CMD_KILL_ALL)) |=> (total_ff == '0) && !armed_ff)
      else $error("kill all left jobs or armed flag");

endmodule

/* hw/rtl/job_slot_quantum_scheduler_top.sv */
// Top level of the job slot quantum scheduler: channel ports, sequencer and
// datapath. Depends on jsqs_pkg, jsqs_ifs, jsqs_ctrl and jsqs_datapath.
//
// One command is in flight at a time; the next is accepted once the current
// command has placed its last result beat in the output register, which may
// still be waiting on rsp_chan. Launch, kill, detach, query and the unused
// code pass from load to a single execute step that registers the result
// beat once the output register is free. Tick, kill all and service walk the
// slot table one slot per cycle, holding while a beat waits for a full output
// register, through a single elapsed-time comparator and slot read port: tick
// walks all slots before its beat, kill all gives one beat per active slot
// (one if none is active) and service stops at the first live slot. Quantum
// writes on csr_chan are always taken and stored in the quantum register.
module job_slot_quantum_scheduler_top (
   input  logic       clock,
   input  logic       reset,
   jsqs_req_if.sink   req_chan,
   jsqs_rsp_if.source rsp_chan,
   jsqs_csr_if.sink   csr_chan
);
   import jsqs_pkg::*;

   op_type   op;
   stat_type stat;

   assign csr_chan.ready = 1'b1;

   jsqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .op        (op)
   );

   jsqs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_chan.cmd),
      .req_prog_id       (req_chan.prog_id),
      .req_ended_mask    (req_chan.ended_mask),
      .csr_valid         (csr_chan.valid),
      .csr_quantum       (csr_chan.quantum),
      .op                (op),
      .stat              (stat),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_preempt       (rsp_chan.preempt),
      .rsp_run_valid     (rsp_chan.run_valid),
      .rsp_run_id        (rsp_chan.run_id),
      .rsp_release_valid (rsp_chan.release_valid),
      .rsp_release_id    (rsp_chan.release_id),
      .rsp_active_jobs   (rsp_chan.active_jobs),
      .rsp_last          (rsp_chan.last)
   );

endmodule

/* tb/sv/jsqs_sched_checker.sv */
// Checker for the job slot quantum scheduler: watches the command, result and
// quantum channels, predicts every result beat and compares it field by field.
// Depends on jsqs_pkg and jsqs_ifs.
module jsqs_sched_checker (
   input  logic clock,
   input  logic reset,
   jsqs_req_if  req_mon,
   jsqs_rsp_if  rsp_mon,
   jsqs_csr_if  csr_mon,
   output int   fail_count,
   output int   pending
);
   import jsqs_pkg::*;

   typedef struct packed {
      logic              status;
      logic              preempt;
      logic              run_valid;
      logic [PID_W-1:0]  run_id;
      logic              release_valid;
      logic [PID_W-1:0]  release_id;
      logic [JOBS_W-1:0] active_jobs;
      logic              last;
   } beat_type;

   beat_type          owed_beats[$];
   logic [TICK_W-1:0] quantum_ticks;
   logic [PID_W-1:0]  slot_pid[SLOTS];
   logic              slot_busy[SLOTS];
   logic [TICK_W-1:0] slot_since[SLOTS];
   logic [JOBS_W-1:0] jobs;
   logic              armed;
   logic              expired;
   logic [TICK_W-1:0] tick_count;

   task automatic release_job();
      if (jobs != '0) begin
         jobs = jobs - 1'b1;
      end
   endtask

   task automatic run_command(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                              logic [MASK_W-1:0] ended);
      beat_type b;
      logic     hit;
      logic     done;
      int       n;
      b      = '0;
      b.last = 1'b1;
      hit    = 1'b0;
      done   = 1'b0;
      n      = 0;
      case (cmd)
         CMD_LAUNCH: begin
            if (pid == '0) begin
               b.status = 1'b1;
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_busy[i] && slot_pid[i] == pid) hit = 1'b1;
               end
               if (!hit) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!slot_busy[i] && !done) begin
                        slot_pid[i]   = pid;
                        slot_busy[i]  = 1'b1;
                        slot_since[i] = tick_count;
                        jobs          = jobs + 1'b1;
                        armed         = 1'b1;
                        done          = 1'b1;
                     end
                  end
                  b.status = !done;
               end
            end
         end
         CMD_KILL, CMD_DETACH: begin
            if (pid != '0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_busy[i] && slot_pid[i] == pid) begin
                     slot_busy[i] = 1'b0;
                     slot_pid[i]  = '0;
                     release_job();
                     hit = 1'b1;
                  end
               end
            end
            if (!hit) begin
               b.status = 1'b1;
            end else begin
               if (jobs == '0) begin
                  armed   = 1'b0;
                  expired = 1'b0;
               end
               if (cmd == CMD_KILL) begin
                  b.release_valid = 1'b1;
                  b.release_id    = pid;
               end
            end
         end
         CMD_KILL_ALL: begin
            jobs    = '0;
            armed   = 1'b0;
            expired = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i]) n++;
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i]) begin
                  n--;
                  b.release_valid = 1'b1;
                  b.release_id    = slot_pid[i];
                  b.last          = (n == 0);
                  b.active_jobs   = jobs;
                  owed_beats.push_back(b);
                  slot_busy[i] = 1'b0;
                  slot_pid[i]  = '0;
                  hit          = 1'b1;
               end
            end
            if (hit) return;
         end
         CMD_TICK: begin
            tick_count = tick_count + 1'b1;
            if (armed && jobs != '0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_busy[i] && (tick_count - slot_since[i]) >= quantum_ticks) begin
                     expired = 1'b1;
                  end
               end
            end
         end
         CMD_QUERY: begin
            if (armed && jobs != '0 && expired) begin
               expired   = 1'b0;
               b.preempt = 1'b1;
            end
         end
         CMD_SERVICE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i] && !done) begin
                  if (i < MASK_W && ended[i]) begin
                     slot_busy[i] = 1'b0;
                     release_job();
                  end else begin
                     slot_since[i] = tick_count;
                     expired       = 1'b0;
                     b.run_valid   = 1'b1;
                     b.run_id      = slot_pid[i];
                     done          = 1'b1;
                  end
               end
            end
            if (!done && jobs == '0) armed = 1'b0;
         end
         default: begin
            b.status = 1'b1;
         end
      endcase
      b.active_jobs = jobs;
      owed_beats.push_back(b);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      beat_type w;
      if (reset) begin
         owed_beats.delete();
         fail_count    = 0;
         quantum_ticks = QUANTUM_RESET;
         jobs          = '0;
         armed         = 1'b0;
         expired       = 1'b0;
         tick_count    = '0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_pid[i]   = '0;
            slot_busy[i]  = 1'b0;
            slot_since[i] = '0;
         end
      end else begin
         if (csr_mon.valid && csr_mon.ready) quantum_ticks = csr_mon.quantum;
         if (req_mon.valid && req_mon.ready) begin
            run_command(req_mon.cmd, req_mon.prog_id, req_mon.ended_mask);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_beats.size() == 0) begin
               $error("result beat with nothing outstanding");
               fail_count++;
            end else begin
               w = owed_beats.pop_front();
               check_field("status", w.status, rsp_mon.status);
               check_field("preempt", w.preempt, rsp_mon.preempt);
               check_field("run_valid", w.run_valid, rsp_mon.run_valid);
               check_field("run_id", w.run_id, rsp_mon.run_id);
               check_field("release_valid", w.release_valid, rsp_mon.release_valid);
               check_field("release_id", w.release_id, rsp_mon.release_id);
               check_field("active_jobs", w.active_jobs, rsp_mon.active_jobs);
               check_field("last", w.last, rsp_mon.last);
            end
         end
      end
      pending = owed_beats.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for job_slot_quantum_scheduler_top: clock, reset, directed and
// random commands, quantum writes and result back-pressure, verdict at the end.
// Depends on jsqs_pkg, jsqs_ifs, the block and jsqs_sched_checker.
module tb_top;
   import jsqs_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PHASE_ITEMS    = 77;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   stall_cycles = 0;
   int   rsp_hold = 0;
   bit   rsp_took = 1'b0;
   bit   rsp_calm = 1'b0;
   bit   req_calm = 1'b0;
   logic [TICK_W-1:0] phase_quantum[5];

   jsqs_req_if req_chan ();
   jsqs_rsp_if rsp_chan ();
   jsqs_csr_if csr_chan ();

   job_slot_quantum_scheduler_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   jsqs_sched_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_took = rsp_chan.valid && rsp_chan.ready;
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold = 0;
         end else begin
            if (rsp_took) begin
               if ($urandom_range(15, 0) == 0) rsp_calm = !rsp_calm;
               rsp_hold = rsp_calm ? 0 : $urandom_range(13, 0);
            end
            if (rsp_hold > 0) begin
               rsp_chan.ready <= 1'b0;
               rsp_hold = rsp_hold - 1;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("job_slot_quantum_scheduler_top verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                           logic [MASK_W-1:0] ended);
      int gap;
      if ($urandom_range(15, 0) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(13, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.prog_id    <= pid;
      req_chan.ended_mask <= ended;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_random();
      int                r;
      logic [CMD_W-1:0]  c;
      logic [PID_W-1:0]  p;
      logic [MASK_W-1:0] m;
      r = $urandom_range(99, 0);
      if (r < 28)      c = CMD_LAUNCH;
      else if (r < 36) c = CMD_KILL;
      else if (r < 42) c = CMD_DETACH;
      else if (r < 45) c = CMD_KILL_ALL;
      else if (r < 67) c = CMD_TICK;
      else if (r < 77) c = CMD_QUERY;
      else if (r < 97) c = CMD_SERVICE;
      else             c = CMD_SPARE;
      p = ($urandom_range(9, 0) < 7) ? PID_W'($urandom_range(6, 1))
                                     : PID_W'($urandom_range(255, 0));
      m = ($urandom_range(4, 0) < 3) ? '0 : MASK_W'($urandom_range(15, 0));
      send_cmd(c, p, m);
   endtask

   task automatic write_quantum(logic [TICK_W-1:0] value);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_chan.valid   <= 1'b1;
      csr_chan.quantum <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_LAUNCH;
      req_chan.prog_id    = '0;
      req_chan.ended_mask = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.quantum    = '0;
      phase_quantum[0] = TICK_W'($urandom_range(8, 3));
      phase_quantum[1] = 32'd1;
      phase_quantum[2] = 32'hFFFF_FFFF;
      phase_quantum[3] = QUANTUM_RESET;
      phase_quantum[4] = TICK_W'($urandom_range(60, 2));
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      write_quantum(32'd2);
      send_cmd(CMD_LAUNCH, 8'd0, 4'h0);
      send_cmd(CMD_KILL, 8'd0, 4'h0);
      send_cmd(CMD_DETACH, 8'd0, 4'h0);
      send_cmd(CMD_KILL, 8'd9, 4'h0);
      send_cmd(CMD_QUERY, 8'd0, 4'h0);
      send_cmd(CMD_SERVICE, 8'd0, 4'h0);
      send_cmd(CMD_KILL_ALL, 8'd0, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd255, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd1, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd255, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd170, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd85, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd7, 4'h0);
      send_cmd(CMD_TICK, 8'd0, 4'h0);
      send_cmd(CMD_TICK, 8'd0, 4'h0);
      send_cmd(CMD_QUERY, 8'd0, 4'h0);
      send_cmd(CMD_QUERY, 8'd0, 4'h0);
      send_cmd(CMD_SERVICE, 8'd0, 4'h3);
      send_cmd(CMD_DETACH, 8'd170, 4'h0);
      send_cmd(CMD_KILL, 8'd85, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd3, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd4, 4'h0);
      send_cmd(CMD_SERVICE, 8'd0, 4'hF);
      send_cmd(CMD_SPARE, 8'd255, 4'hF);
      send_cmd(CMD_LAUNCH, 8'd3, 4'h0);
      send_cmd(CMD_LAUNCH, 8'd6, 4'h0);
      send_cmd(CMD_KILL_ALL, 8'd0, 4'h0);

      foreach (phase_quantum[ph]) begin
         write_quantum(phase_quantum[ph]);
         repeat (PHASE_ITEMS) send_random();
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("job_slot_quantum_scheduler_top verification clean");
      end else begin
         $display("job_slot_quantum_scheduler_top verification failed");
      end
      $finish;
   end

endmodule
